### design/ipv4hc_pkg.sv
// Package with the item types, verdict codes and header constants of the IPv4 header check.
`default_nettype none

package ipv4hc_pkg;

  // Verdict codes, given at most once per packet.
  typedef enum logic [3:0] {
    VERDICT_UDP           = 4'd0,
    VERDICT_TCP           = 4'd1,
    VERDICT_ICMP          = 4'd2,
    VERDICT_PROTO_UNREACH = 4'd3,
    VERDICT_BAD_VERSION   = 4'd4,
    VERDICT_BAD_LENGTH    = 4'd5,
    VERDICT_BAD_CHECKSUM  = 4'd6,
    VERDICT_NOT_FOR_US    = 4'd7,
    VERDICT_UDP_SHORT     = 4'd8
  } verdict_e;

  // Byte positions inside the IPv4 header.
  localparam logic [5:0] IDX_VER_IHL   = 6'd0;
  localparam logic [5:0] IDX_TLEN_HI   = 6'd2;
  localparam logic [5:0] IDX_TLEN_LO   = 6'd3;
  localparam logic [5:0] IDX_PROTO     = 6'd9;
  localparam logic [5:0] IDX_CSUM_HI   = 6'd10;
  localparam logic [5:0] IDX_CSUM_LO   = 6'd11;
  localparam logic [5:0] IDX_SRC_FIRST = 6'd12;
  localparam logic [5:0] IDX_SRC_LAST  = 6'd15;
  localparam logic [5:0] IDX_DST_FIRST = 6'd16;
  localparam logic [5:0] IDX_DST_LAST  = 6'd19;

  // Header constants.
  localparam logic [3:0]  IP_VERSION4 = 4'd4;
  localparam logic [5:0]  MIN_HEADER  = 6'd20;
  localparam logic [15:0] UDP_HEADER  = 16'd8;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  // One packet byte as it arrives.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_packet;
    logic [15:0] frame_len;
  } in_item_t;

  // One verdict with the header fields that go with it.
  typedef struct packed {
    verdict_e    verdict;
    logic [5:0]  header_bytes;
    logic [15:0] ip_len;
    logic [7:0]  protocol;
    logic [31:0] source_ip;
  } res_item_t;

  // Result of the parser for one processed byte.
  typedef struct packed {
    logic      emit;
    res_item_t item;
  } parse_out_t;

endpackage

`default_nettype wire

### design/ipv4hc_chan_if.sv
// Valid/ready channel interface carrying one payload per request.
`default_nettype none

interface ipv4hc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/ipv4hc_parse.sv
// Byte parser of the IPv4 header: field capture, checksum sum and verdict logic.
`default_nettype none

module ipv4hc_parse (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire ipv4hc_pkg::in_item_t  item_i,
  input  wire logic [31:0]           local_ip_i,
  output ipv4hc_pkg::parse_out_t     out_o
);

  // Parser state.
  logic        active_q, active_d;
  logic [5:0]  idx_q, idx_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [5:0]  hlen_q, hlen_d;
  logic [15:0] tlen_q, tlen_d;
  logic [15:0] flen_q, flen_d;
  logic [15:0] csum_q, csum_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  // Values after a possible restart on the first byte.
  logic        cur_active;
  logic [15:0] cur_sum, cur_tlen, cur_csum;
  logic [7:0]  cur_hold;
  logic [31:0] cur_src, cur_dst;
  logic [7:0]  b;

  // Checksum adder with end-around carry.
  logic [16:0] add_w;
  logic [15:0] fold_w;

  logic        emit;
  ipv4hc_pkg::verdict_e verdict;
  logic [15:0] udp_len;

  assign b = item_i.data_byte;

  always_comb begin
    // A first byte clears the packet state and samples the frame length.
    cur_active = active_q;
    cur_sum    = sum_q;
    cur_hold   = hold_q;
    cur_tlen   = tlen_q;
    cur_csum   = csum_q;
    cur_src    = src_q;
    cur_dst    = dst_q;
    idx_d      = idx_q;
    hlen_d     = hlen_q;
    flen_d     = flen_q;
    proto_d    = proto_q;
    if (item_i.first_of_packet) begin
      cur_active = 1'b1;
      cur_sum    = '0;
      cur_hold   = '0;
      cur_tlen   = '0;
      cur_csum   = '0;
      cur_src    = '0;
      cur_dst    = '0;
      idx_d      = '0;
      hlen_d     = '0;
      flen_d     = item_i.frame_len;
      proto_d    = '0;
    end

    sum_d    = cur_sum;
    hold_d   = cur_hold;
    tlen_d   = cur_tlen;
    csum_d   = cur_csum;
    src_d    = cur_src;
    dst_d    = cur_dst;
    active_d = cur_active;
    emit     = 1'b0;
    verdict  = ipv4hc_pkg::VERDICT_UDP;

    // Ones-complement sum of 16-bit words; the checksum word is skipped.
    add_w  = {1'b0, cur_sum} + {1'b0, cur_hold, b};
    fold_w = add_w[15:0] + {15'd0, add_w[16]};
    udp_len = '0;

    if (cur_active) begin
      if (idx_d[0]) begin
        if (idx_d != ipv4hc_pkg::IDX_CSUM_LO) begin
          sum_d = fold_w;
        end
      end else begin
        hold_d = b;
      end

      // Field capture and the early checks.
      case (idx_d) inside
        ipv4hc_pkg::IDX_VER_IHL: begin
          hlen_d = {b[3:0], 2'b00};
          if (b[7:4] != ipv4hc_pkg::IP_VERSION4) begin
            hlen_d  = '0;
            emit    = 1'b1;
            verdict = ipv4hc_pkg::VERDICT_BAD_VERSION;
          end
        end
        ipv4hc_pkg::IDX_TLEN_HI: tlen_d = {b, 8'h00};
        ipv4hc_pkg::IDX_TLEN_LO: begin
          tlen_d = {cur_tlen[15:8], b};
          if ((hlen_d < ipv4hc_pkg::MIN_HEADER) || (tlen_d < {10'd0, hlen_d}) ||
              (flen_d < tlen_d)) begin
            emit    = 1'b1;
            verdict = ipv4hc_pkg::VERDICT_BAD_LENGTH;
          end
        end
        ipv4hc_pkg::IDX_PROTO:   proto_d = b;
        ipv4hc_pkg::IDX_CSUM_HI: csum_d = {b, 8'h00};
        ipv4hc_pkg::IDX_CSUM_LO: csum_d = {cur_csum[15:8], b};
        [ipv4hc_pkg::IDX_SRC_FIRST:ipv4hc_pkg::IDX_SRC_LAST]: src_d = {cur_src[23:0], b};
        [ipv4hc_pkg::IDX_DST_FIRST:ipv4hc_pkg::IDX_DST_LAST]: dst_d = {cur_dst[23:0], b};
        default: ;
      endcase

      // Last header byte: checksum, address match, then protocol class.
      udp_len = tlen_d - {10'd0, hlen_d};
      if (!emit && (idx_d >= ipv4hc_pkg::IDX_TLEN_LO) && ((idx_d + 6'd1) == hlen_d)) begin
        emit = 1'b1;
        if (~sum_d != csum_d) begin
          verdict = ipv4hc_pkg::VERDICT_BAD_CHECKSUM;
        end else if (dst_d != local_ip_i) begin
          verdict = ipv4hc_pkg::VERDICT_NOT_FOR_US;
        end else begin
          case (proto_d)
            ipv4hc_pkg::PROTO_UDP: verdict = (udp_len < ipv4hc_pkg::UDP_HEADER) ?
                                             ipv4hc_pkg::VERDICT_UDP_SHORT :
                                             ipv4hc_pkg::VERDICT_UDP;
            ipv4hc_pkg::PROTO_TCP:  verdict = ipv4hc_pkg::VERDICT_TCP;
            ipv4hc_pkg::PROTO_ICMP: verdict = ipv4hc_pkg::VERDICT_ICMP;
            default:                verdict = ipv4hc_pkg::VERDICT_PROTO_UNREACH;
          endcase
        end
      end

      // After a verdict the rest of the packet is ignored.
      if (emit) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_d + 6'd1;
      end
    end
  end

  assign out_o.emit              = emit;
  assign out_o.item.verdict      = verdict;
  assign out_o.item.header_bytes = hlen_d;
  assign out_o.item.ip_len       = tlen_d;
  assign out_o.item.protocol     = proto_d;
  assign out_o.item.source_ip    = src_d;

  // State registers advance once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      sum_q    <= '0;
      hold_q   <= '0;
      hlen_q   <= '0;
      tlen_q   <= '0;
      flen_q   <= '0;
      csum_q   <= '0;
      proto_q  <= '0;
      src_q    <= '0;
      dst_q    <= '0;
    end else if (en_i) begin
      active_q <= active_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      hold_q   <= hold_d;
      hlen_q   <= hlen_d;
      tlen_q   <= tlen_d;
      flen_q   <= flen_d;
      csum_q   <= csum_d;
      proto_q  <= proto_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
    end
  end

endmodule

`default_nettype wire

### design/ipv4_receive_header_check_unit.sv
// Top level of the IPv4 receive header check: input stage, parser, result register.
//
//   channel   dir  payload      request moves
//   in_if     in   in_item_t    one packet byte
//   res_if    out  res_item_t   at most one verdict per packet
//   cfg_if    in   32 bits      a new local address (always ready)
//
// One byte per cycle while the result register is free or drains: an accepted byte
// is parsed once it sits in the input register and the result register is free or
// drains, and its verdict, if any, is then registered in the result register, which
// raises the verdict request. While a verdict waits in the result register the parser
// stalls and the input register takes at most one more byte. Reset clears all
// control state and the local address to zero; the parser idles until a first byte.
`default_nettype none

module ipv4_receive_header_check_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ipv4hc_chan_if.sink   in_if,
  ipv4hc_chan_if.source res_if,
  ipv4hc_chan_if.sink   cfg_if
);

  logic [31:0] local_ip_q;

  ipv4hc_pkg::in_item_t   s1_q;
  logic                   s1_valid_q, s1_valid_d;
  ipv4hc_pkg::res_item_t  res_q;
  logic                   res_valid_q, res_valid_d;
  ipv4hc_pkg::parse_out_t parse_out;
  logic                   out_free;
  logic                   proc_en;

  // Configuration register.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
    end else if (cfg_if.valid) begin
      local_ip_q <= cfg_if.payload;
    end
  end

  // Handshake control: the byte in the input register is parsed when the
  // result register is free or drains in this cycle.
  assign out_free    = !res_valid_q || res_if.ready;
  assign proc_en     = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || out_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_if.ready) begin
      s1_valid_d = in_if.valid;
    end
    res_valid_d = res_valid_q;
    if (out_free) begin
      res_valid_d = proc_en && parse_out.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_q <= in_if.payload;
    end
    if (proc_en && parse_out.emit) begin
      res_q <= parse_out.item;
    end
  end

  // Header parser.
  ipv4hc_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (proc_en),
    .item_i     (s1_q),
    .local_ip_i (local_ip_q),
    .out_o      (parse_out)
  );

  assign res_if.valid   = res_valid_q;
  assign res_if.payload = res_q;

  // A new verdict request only follows a parsed byte that produced one.
  a_res_from_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(proc_en) && $past(parse_out.emit))
    else $error("verdict request without a parsed verdict");

  // A byte waiting in the input register is not lost while the output stalls.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q && $stable(s1_q))
    else $error("stalled input byte dropped or changed");

  // A configuration write lands in the local address register.
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_if.valid |=> local_ip_q == $past(cfg_if.payload))
    else $error("local address not updated by configuration write");

endmodule

`default_nettype wire

### test/ipv4_receive_header_check_unit_tb.sv
// Self-checking testbench for the IPv4 receive header check unit with random stalls.
module ipv4_receive_header_check_unit_tb;

  // Verdict predictor: follows the parser byte by byte and queues the verdict
  // each packet should produce, then compares arriving verdicts in order.
  class ipv4_verdict_predictor;
    logic [31:0] local_addr;
    logic [5:0]  byte_pos;
    int unsigned csum_acc;
    logic [7:0]  hi_hold;
    logic [5:0]  hdr_bytes;
    logic [15:0] tot_len;
    logic [15:0] frm_len;
    logic [15:0] rx_csum;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    bit          idle;
    ipv4hc_pkg::res_item_t pending_verdicts[$];
    int          bytes_parsed;
    int          verdicts_predicted;
    int          verdicts_checked;
    int          mismatch_count;
    int          verdict_hits[9];

    function new();
      local_addr = '0;
      clear_packet();
      idle = 1'b1;
      bytes_parsed = 0;
      verdicts_predicted = 0;
      verdicts_checked = 0;
      mismatch_count = 0;
      foreach (verdict_hits[i]) verdict_hits[i] = 0;
    endfunction

    function void clear_packet();
      byte_pos = '0;
      csum_acc = 0;
      hi_hold  = '0;
      hdr_bytes = '0;
      tot_len  = '0;
      frm_len  = '0;
      rx_csum  = '0;
      proto    = '0;
      src_addr = '0;
      dst_addr = '0;
    endfunction

    function void post_verdict(ipv4hc_pkg::verdict_e v);
      ipv4hc_pkg::res_item_t r;
      r.verdict      = v;
      r.header_bytes = hdr_bytes;
      r.ip_len       = tot_len;
      r.protocol     = proto;
      r.source_ip    = src_addr;
      pending_verdicts.push_back(r);
      verdicts_predicted++;
      idle = 1'b1;
    endfunction

    // Checksum first, then address, then protocol class.
    function ipv4hc_pkg::verdict_e classify();
      logic [15:0] folded_inv;
      folded_inv = ~csum_acc[15:0];
      if (folded_inv != rx_csum) return ipv4hc_pkg::VERDICT_BAD_CHECKSUM;
      if (dst_addr != local_addr) return ipv4hc_pkg::VERDICT_NOT_FOR_US;
      case (proto)
        ipv4hc_pkg::PROTO_UDP:
          return (int'(tot_len) - int'(hdr_bytes) < int'(ipv4hc_pkg::UDP_HEADER)) ?
                 ipv4hc_pkg::VERDICT_UDP_SHORT : ipv4hc_pkg::VERDICT_UDP;
        ipv4hc_pkg::PROTO_TCP:  return ipv4hc_pkg::VERDICT_TCP;
        ipv4hc_pkg::PROTO_ICMP: return ipv4hc_pkg::VERDICT_ICMP;
        default:                return ipv4hc_pkg::VERDICT_PROTO_UNREACH;
      endcase
    endfunction

    // Called for every accepted input request.
    function void take_byte(ipv4hc_pkg::in_item_t it);
      logic [7:0] b;
      logic [5:0] pos;
      if (it.first_of_packet) begin
        clear_packet();
        frm_len = it.frame_len;
        idle = 1'b0;
      end
      if (idle) return;
      b = it.data_byte;
      pos = byte_pos;
      bytes_parsed++;

      // Ones-complement sum over header words, checksum word skipped.
      if (pos[0]) begin
        if (pos != ipv4hc_pkg::IDX_CSUM_LO) begin
          csum_acc = csum_acc + {hi_hold, b};
          csum_acc = (csum_acc & 32'h0000_ffff) + (csum_acc >> 16);
        end
      end else begin
        hi_hold = b;
      end

      // Field capture and the early checks.
      case (pos)
        ipv4hc_pkg::IDX_VER_IHL: begin
          hdr_bytes = {b[3:0], 2'b00};
          if (b[7:4] != ipv4hc_pkg::IP_VERSION4) begin
            hdr_bytes = '0;
            post_verdict(ipv4hc_pkg::VERDICT_BAD_VERSION);
            return;
          end
        end
        ipv4hc_pkg::IDX_TLEN_HI: tot_len = {b, 8'h00};
        ipv4hc_pkg::IDX_TLEN_LO: begin
          tot_len[7:0] = b;
          if (hdr_bytes < ipv4hc_pkg::MIN_HEADER || tot_len < hdr_bytes ||
              frm_len < tot_len) begin
            post_verdict(ipv4hc_pkg::VERDICT_BAD_LENGTH);
            return;
          end
        end
        ipv4hc_pkg::IDX_PROTO:   proto = b;
        ipv4hc_pkg::IDX_CSUM_HI: rx_csum = {b, 8'h00};
        ipv4hc_pkg::IDX_CSUM_LO: rx_csum[7:0] = b;
        default: begin
          if (pos >= ipv4hc_pkg::IDX_SRC_FIRST && pos <= ipv4hc_pkg::IDX_SRC_LAST)
            src_addr = {src_addr[23:0], b};
          else if (pos >= ipv4hc_pkg::IDX_DST_FIRST && pos <= ipv4hc_pkg::IDX_DST_LAST)
            dst_addr = {dst_addr[23:0], b};
        end
      endcase

      if (pos >= ipv4hc_pkg::IDX_TLEN_LO && int'(pos) + 1 == int'(hdr_bytes)) begin
        post_verdict(classify());
        return;
      end
      byte_pos = pos + 6'd1;
    endfunction

    // Called for every accepted result request.
    function void check_verdict(ipv4hc_pkg::res_item_t got);
      ipv4hc_pkg::res_item_t exp;
      if (pending_verdicts.size() == 0) begin
        $error("verdict %0d arrived with no packet pending", got.verdict);
        mismatch_count++;
        return;
      end
      exp = pending_verdicts.pop_front();
      verdicts_checked++;
      verdict_hits[int'(exp.verdict)]++;
      if (got.verdict !== exp.verdict) begin
        $error("verdict: expected %0d, got %0d", exp.verdict, got.verdict);
        mismatch_count++;
      end
      if (got.header_bytes !== exp.header_bytes) begin
        $error("header_bytes: expected %0d, got %0d", exp.header_bytes, got.header_bytes);
        mismatch_count++;
      end
      if (got.ip_len !== exp.ip_len) begin
        $error("ip_len: expected %0d, got %0d", exp.ip_len, got.ip_len);
        mismatch_count++;
      end
      if (got.protocol !== exp.protocol) begin
        $error("protocol: expected %0d, got %0d", exp.protocol, got.protocol);
        mismatch_count++;
      end
      if (got.source_ip !== exp.source_ip) begin
        $error("source_ip: expected %h, got %h", exp.source_ip, got.source_ip);
        mismatch_count++;
      end
    endfunction

    function void check_drained();
      if (pending_verdicts.size() != 0) begin
        $error("%0d verdicts never arrived", pending_verdicts.size());
        mismatch_count += pending_verdicts.size();
      end
    endfunction
  endclass

  // Description of one generated header.
  typedef struct {
    int          ihl;
    logic [3:0]  ver;
    logic [15:0] tot;
    logic [15:0] frame;
    logic [7:0]  proto;
    logic [31:0] dst;
    bit          good_csum;
    bit          all_ones;
  } hdr_spec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ipv4hc_chan_if #(.payload_t(ipv4hc_pkg::in_item_t))  in_if ();
  ipv4hc_chan_if #(.payload_t(ipv4hc_pkg::res_item_t)) res_if ();
  ipv4hc_chan_if #(.payload_t(logic [31:0]))           cfg_if ();

  ipv4_receive_header_check_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  ipv4_verdict_predictor verdicts = new();
  bit         no_idle = 1'b0;
  int         addr_writes = 0;
  int         bytes_sent = 0;
  logic [7:0] pkt_bytes[$];

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Give up if the run hangs.
  initial begin
    #400000;
    $error("run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, every accepted verdict goes to the checker.
  initial begin : verdict_sink
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      verdicts.check_verdict(res_if.payload);
    end
  end

  // One input request after a random gap.
  task automatic send_byte(input ipv4hc_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    verdicts.take_byte(it);
    bytes_sent++;
  endtask

  // Header bytes with a checksum that is correct unless the spec says otherwise.
  function automatic void build_header(hdr_spec_t s);
    int          n;
    int unsigned acc;
    logic [15:0] cs;
    n = (s.ihl * 4 < 20) ? 20 : s.ihl * 4;
    pkt_bytes.delete();
    for (int i = 0; i < n; i++) pkt_bytes.push_back(s.all_ones ? 8'hff : 8'($urandom));
    pkt_bytes[0]  = {s.ver, 4'(s.ihl)};
    pkt_bytes[2]  = s.tot[15:8];
    pkt_bytes[3]  = s.tot[7:0];
    pkt_bytes[9]  = s.proto;
    pkt_bytes[10] = 8'h00;
    pkt_bytes[11] = 8'h00;
    for (int i = 0; i < 4; i++) pkt_bytes[16 + i] = s.dst[31 - 8 * i -: 8];
    acc = 0;
    for (int i = 0; i < n; i += 2) acc += {pkt_bytes[i], pkt_bytes[i + 1]};
    acc = (acc & 32'h0000_ffff) + (acc >> 16);
    acc = (acc & 32'h0000_ffff) + (acc >> 16);
    cs = ~acc[15:0];
    if (!s.good_csum) cs ^= 16'($urandom_range(1, 65535));
    pkt_bytes[10] = cs[15:8];
    pkt_bytes[11] = cs[7:0];
  endfunction

  // Sends the first keep bytes of a header (all if keep is 0), then trailing noise.
  task automatic send_packet(input hdr_spec_t s, input int keep, input int trail);
    ipv4hc_pkg::in_item_t it;
    build_header(s);
    if (keep <= 0 || keep > pkt_bytes.size()) keep = pkt_bytes.size();
    for (int i = 0; i < keep; i++) begin
      it.data_byte       = pkt_bytes[i];
      it.first_of_packet = (i == 0);
      it.frame_len       = (i == 0) ? s.frame : 16'($urandom);
      send_byte(it);
    end
    repeat (trail) begin
      it.data_byte       = 8'($urandom);
      it.first_of_packet = 1'b0;
      it.frame_len       = 16'($urandom);
      send_byte(it);
    end
  endtask

  function automatic hdr_spec_t good_spec(int ihl, logic [15:0] tot, logic [7:0] proto);
    hdr_spec_t s;
    s.ihl       = ihl;
    s.ver       = ipv4hc_pkg::IP_VERSION4;
    s.tot       = tot;
    s.frame     = tot;
    s.proto     = proto;
    s.dst       = verdicts.local_addr;
    s.good_csum = 1'b1;
    s.all_ones  = 1'b0;
    return s;
  endfunction

  // Mostly well-formed packets; some carry bad fields, some are cut short.
  task automatic send_random_packet();
    hdr_spec_t s;
    int        r;
    int        hdr;
    int        keep;
    no_idle = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    s.ihl = (r < 60) ? 5 : (r < 95) ? $urandom_range(5, 15) : $urandom_range(0, 4);
    s.ver = ($urandom_range(0, 99) < 92) ? ipv4hc_pkg::IP_VERSION4 : 4'($urandom);
    hdr = s.ihl * 4;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      s.tot = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(hdr, 65535)) :
              16'(hdr + $urandom_range(0, 40));
      s.frame = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(s.tot, 65535)) : s.tot;
    end else if (r < 93 && hdr > 0) begin
      s.tot   = 16'($urandom_range(0, hdr - 1));
      s.frame = 16'($urandom_range(s.tot, 65535));
    end else begin
      s.tot   = 16'($urandom_range(1, 65535));
      s.frame = 16'($urandom_range(0, s.tot - 1));
    end
    case ($urandom_range(0, 3))
      0:       s.proto = ipv4hc_pkg::PROTO_UDP;
      1:       s.proto = ipv4hc_pkg::PROTO_TCP;
      2:       s.proto = ipv4hc_pkg::PROTO_ICMP;
      default: s.proto = 8'($urandom);
    endcase
    s.dst = ($urandom_range(0, 99) < 85) ? verdicts.local_addr : 32'($urandom);
    s.good_csum = ($urandom_range(0, 99) < 88);
    s.all_ones = 1'b0;
    keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 19) : 0;
    send_packet(s, keep, $urandom_range(0, 3));
  endtask

  // Address register write; only called with nothing in flight.
  task automatic write_local_ip(input logic [31:0] addr);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= addr;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    verdicts.local_addr = addr;
    addr_writes++;
  endtask

  // Hold the input until every verdict is back and ignored bytes have flushed.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (verdicts.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin : stimulus
    hdr_spec_t   s;
    logic [31:0] addr_list[5];
    int          start_sent;
    ipv4hc_pkg::in_item_t it;

    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets.
    write_local_ip(32'hffff_ffff);

    // Bytes before any packet start are ignored.
    repeat (3) begin
      it.data_byte       = 8'h45;
      it.first_of_packet = 1'b0;
      it.frame_len       = 16'hffff;
      send_byte(it);
    end

    // Bad version at both extremes of the first byte.
    s = good_spec(0, 16'd20, ipv4hc_pkg::PROTO_UDP);
    s.ver = 4'h0;
    send_packet(s, 0, 1);
    s = good_spec(15, 16'd60, ipv4hc_pkg::PROTO_UDP);
    s.ver = 4'hf;
    send_packet(s, 0, 0);

    // Length failures: short header, total under header, frame under total.
    send_packet(good_spec(4, 16'd40, ipv4hc_pkg::PROTO_UDP), 0, 0);
    send_packet(good_spec(5, 16'd19, ipv4hc_pkg::PROTO_TCP), 0, 0);
    s = good_spec(5, 16'd100, ipv4hc_pkg::PROTO_TCP);
    s.frame = 16'd99;
    send_packet(s, 0, 0);
    s = good_spec(5, 16'd0, ipv4hc_pkg::PROTO_TCP);
    s.frame = 16'd0;
    send_packet(s, 0, 0);

    // A packet cut short by a new start gives no verdict.
    send_packet(good_spec(5, 16'd28, ipv4hc_pkg::PROTO_UDP), 10, 0);

    // All-ones header drives the sum through many carries.
    s = good_spec(15, 16'hffff, 8'hff);
    s.all_ones = 1'b1;
    send_packet(s, 0, 2);

    // Every protocol class and the short UDP boundary.
    send_packet(good_spec(5, 16'd28, ipv4hc_pkg::PROTO_UDP), 0, 0);
    send_packet(good_spec(5, 16'd27, ipv4hc_pkg::PROTO_UDP), 0, 0);
    send_packet(good_spec(6, 16'd24, ipv4hc_pkg::PROTO_UDP), 0, 1);
    send_packet(good_spec(5, 16'd40, ipv4hc_pkg::PROTO_TCP), 0, 0);
    send_packet(good_spec(5, 16'd84, ipv4hc_pkg::PROTO_ICMP), 0, 0);
    s = good_spec(7, 16'd60, 8'h00);
    s.frame = 16'hffff;
    send_packet(s, 0, 0);

    // Checksum and address failures.
    s = good_spec(5, 16'd40, ipv4hc_pkg::PROTO_TCP);
    s.good_csum = 1'b0;
    send_packet(s, 0, 0);
    s = good_spec(5, 16'd40, ipv4hc_pkg::PROTO_TCP);
    s.dst = 32'h0a00_0001;
    send_packet(s, 0, 0);
    drain();

    // Random phases, each under its own local address.
    addr_list[0] = 32'h0000_0000;
    addr_list[1] = 32'hffff_ffff;
    addr_list[2] = 32'($urandom);
    addr_list[3] = 32'($urandom);
    addr_list[4] = 32'($urandom);
    foreach (addr_list[p]) begin
      write_local_ip(addr_list[p]);
      start_sent = bytes_sent;
      while (bytes_sent - start_sent < 40)
        send_random_packet();
      no_idle = 1'b0;
      drain();
    end

    verdicts.check_drained();
    $display("Covered %0d sent bytes, %0d parsed, %0d verdicts checked, %0d address writes.",
             bytes_sent, verdicts.bytes_parsed, verdicts.verdicts_checked, addr_writes);
    $display("Verdicts: udp %0d tcp %0d icmp %0d unreach %0d version %0d",
             verdicts.verdict_hits[0], verdicts.verdict_hits[1], verdicts.verdict_hits[2],
             verdicts.verdict_hits[3], verdicts.verdict_hits[4]);
    $display("          length %0d csum %0d foreign %0d short %0d",
             verdicts.verdict_hits[5], verdicts.verdict_hits[6], verdicts.verdict_hits[7],
             verdicts.verdict_hits[8]);
    if (verdicts.mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
